// ----- rtl/rdm_pkg.sv -----
// ----------------------------------------------------------------------------
// rdm_pkg
// Event codes, result status codes and shared types of the deadlock manager.
// ----------------------------------------------------------------------------
package rdm_pkg;

	// event codes
	localparam logic [2:0] OP_LOAD   = 3'd0;
	localparam logic [2:0] OP_START  = 3'd1;
	localparam logic [2:0] OP_EXIT   = 3'd2;
	localparam logic [2:0] OP_ACQ    = 3'd3;
	localparam logic [2:0] OP_REL    = 3'd4;
	localparam logic [2:0] OP_RETRY  = 3'd5;
	localparam logic [2:0] OP_DETECT = 3'd6;

	// result status codes
	localparam logic [2:0] ST_GRANTED  = 3'd0;
	localparam logic [2:0] ST_BLOCKED  = 3'd1;
	localparam logic [2:0] ST_RELEASED = 3'd2;
	localparam logic [2:0] ST_DENIED   = 3'd3;
	localparam logic [2:0] ST_KILLED   = 3'd4;
	localparam logic [2:0] ST_SAFE     = 3'd5;
	localparam logic [2:0] ST_DONE     = 3'd6;

	// operand width of the shared arithmetic unit (widest counter)
	localparam int OPW = 16;

	typedef struct packed {
		logic [OPW-1:0] a;
		logic [OPW-1:0] b;
		logic           work_mode;
	} alu_req_t;

	typedef struct packed {
		logic [OPW-1:0] sum;
		logic [OPW-1:0] diff;
		logic           ge;
		logic           ovf;
	} alu_rsp_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] proc;
	} res_item_t;

endpackage

// ----- rtl/resource_deadlock_manager.sv -----
// ----------------------------------------------------------------------------
// resource_deadlock_manager
// Resource table, allocation matrix and blocked requests with deadlock repair.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_stall with op, proc_index, resource_index
// and amount; one request is taken when req_valid is high and req_stall low.
// Results leave on res_valid/res_stall, one or more per request, the final
// one flagged by last. Results are collected in a small queue and sent once
// the request is finished, so free_units and grant_count are final values.
// Load, start of an active process and denials queue their result at
// dispatch; acquire and release check the held units, then the free table;
// start and exit walk one row of the allocation matrix. Retry walks the
// process table and checks each blocked request. Detection copies the free
// table, scans processes one per cycle and adds a finished process's row
// resource by resource, repeating per kill. All arithmetic goes through the
// one shared adder/compare unit, and all allocation accesses through the one
// write and one registered read port of the allocation memory. req_stall
// stays high until all results of a request are in the output register. After
// reset a clearing pass zeroes the allocation memory while req_stall is high.
// A stalled result holds in the output register; the block may already
// take the next request meanwhile.
// ----------------------------------------------------------------------------
module resource_deadlock_manager #(
	parameter int PROCS = 16,
	parameter int RESOURCES = 16,
	parameter int AMOUNT_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [2:0] op,
	input  logic [3:0] proc_index,
	input  logic [3:0] resource_index,
	input  logic [7:0] amount,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [2:0] status,
	output logic [3:0] result_proc,
	output logic [4:0] grant_count,
	output logic [7:0] free_units,
	output logic       last
);
	import rdm_pkg::*;

	localparam int PW = $clog2(PROCS);
	localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
	localparam int AB = AMOUNT_BITS;
	localparam int WW = (AMOUNT_BITS > 12) ? AMOUNT_BITS : 12;
	localparam int AW = PW + RW;
	localparam int CW = $clog2(PROCS + 1);

	// sequencer states
	localparam logic [4:0] S_CLR     = 5'd0;
	localparam logic [4:0] S_IDLE    = 5'd1;
	localparam logic [4:0] S_DISP    = 5'd2;
	localparam logic [4:0] S_ZROW    = 5'd3;
	localparam logic [4:0] S_RET_RD  = 5'd4;
	localparam logic [4:0] S_RET_ADD = 5'd5;
	localparam logic [4:0] S_ACQ_E1  = 5'd6;
	localparam logic [4:0] S_ACQ_E2  = 5'd7;
	localparam logic [4:0] S_REL_E1  = 5'd8;
	localparam logic [4:0] S_REL_E2  = 5'd9;
	localparam logic [4:0] S_RT_CHK  = 5'd10;
	localparam logic [4:0] S_RT_E1   = 5'd11;
	localparam logic [4:0] S_RT_E2   = 5'd12;
	localparam logic [4:0] S_INIT    = 5'd13;
	localparam logic [4:0] S_SCAN    = 5'd14;
	localparam logic [4:0] S_DA_RD   = 5'd15;
	localparam logic [4:0] S_DA_ADD  = 5'd16;
	localparam logic [4:0] S_FLUSH   = 5'd17;

	logic [4:0] state_q;

	// latched request
	logic [2:0]    op_q;
	logic [PW-1:0] p_q;
	logic [RW-1:0] r_q;
	logic [AB-1:0] v_q;
	logic          pok_q;
	logic          rok_q;

	// tables
	logic [AB-1:0]    free_q [RESOURCES];
	logic [PROCS-1:0] active_q;
	logic [PROCS-1:0] bv_q;
	logic [RW-1:0]    bres_q [PROCS];
	logic [AB-1:0]    ba_q [PROCS];
	logic [WW-1:0]    work_q [RESOURCES];
	logic [PROCS-1:0] fin_q;

	// sequencer counters and scratch
	logic [PW-1:0] i_q;
	logic [RW-1:0] j_q;
	logic [AW-1:0] clr_q;
	logic [PW-1:0] rp_q;
	logic          kill_q;
	logic [PW-1:0] d_q;
	logic          dval_q;
	logic [AB-1:0] tmp_q;
	logic [CW-1:0] grants_q;

	// result queue
	localparam int IW = (PROCS > 1) ? $clog2(PROCS) : 1;
	res_item_t     q_mem [PROCS];
	logic [CW-1:0] q_wr_q;
	logic [CW-1:0] q_rd_q;
	res_item_t     q_head;
	logic          q_last;

	// output register
	logic       res_valid_q;
	logic [2:0] res_status_q;
	logic [3:0] res_proc_q;
	logic [4:0] res_grants_q;
	logic [7:0] res_free_q;
	logic       res_last_q;

	// shared unit and memory port
	alu_req_t      alu_req;
	alu_rsp_t      alu_rsp;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AB-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [AB-1:0] ram_rdata;

	logic [RW-1:0] fa;
	logic [RW-1:0] wa;
	logic [AB-1:0] free_rd;
	logic [WW-1:0] work_rd;
	logic [RW-1:0] br_i;
	logic          i_last;
	logic          j_last;
	logic          req_ok;
	logic          scan_go;
	logic [PW-1:0] kd;
	logic [15:0]   free_wide;

	assign br_i = bres_q[i_q];
	assign i_last = (i_q == PW'(PROCS - 1));
	assign j_last = (j_q == RW'(RESOURCES - 1));
	assign req_ok = pok_q && rok_q && active_q[p_q] && !bv_q[p_q];
	assign scan_go = !bv_q[i_q] || alu_rsp.ge;
	assign kd = dval_q ? d_q : i_q;
	assign q_head = q_mem[q_rd_q[IW-1:0]];
	assign q_last = ((q_rd_q + 1'b1) == q_wr_q);
	assign free_wide = 16'(free_rd);

	rdm_alu #(
		.AMOUNT_BITS(AB),
		.WORK_BITS(WW)
	) u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	rdm_held_ram #(
		.AW(AW),
		.DW(AB)
	) u_held (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// operand, table port and memory port selection per state
	always_comb begin
		fa = r_q;
		wa = j_q;
		ram_raddr = {p_q, r_q};
		ram_we = 1'b0;
		ram_waddr = {p_q, r_q};
		ram_wdata = '0;
		alu_req.a = '0;
		alu_req.b = '0;
		alu_req.work_mode = 1'b0;
		unique case (state_q)
			S_CLR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
			end
			S_ACQ_E1: begin
				alu_req.a = OPW'(ram_rdata);
				alu_req.b = OPW'(v_q);
			end
			S_ACQ_E2: begin
				alu_req.a = OPW'(free_q[r_q]);
				alu_req.b = OPW'(v_q);
				ram_we = alu_rsp.ge;
				ram_wdata = tmp_q;
			end
			S_REL_E1: begin
				alu_req.a = OPW'(ram_rdata);
				alu_req.b = OPW'(v_q);
				ram_we = alu_rsp.ge;
				ram_wdata = alu_rsp.diff[AB-1:0];
			end
			S_REL_E2: begin
				alu_req.a = OPW'(free_q[r_q]);
				alu_req.b = OPW'(v_q);
			end
			S_ZROW: begin
				ram_we = 1'b1;
				ram_waddr = {p_q, j_q};
			end
			S_RET_RD: begin
				ram_raddr = {rp_q, j_q};
			end
			S_RET_ADD: begin
				fa = j_q;
				alu_req.a = OPW'(free_q[j_q]);
				alu_req.b = OPW'(ram_rdata);
				ram_we = 1'b1;
				ram_waddr = {rp_q, j_q};
			end
			S_RT_CHK: begin
				ram_raddr = {i_q, br_i};
			end
			S_RT_E1: begin
				alu_req.a = OPW'(ram_rdata);
				alu_req.b = OPW'(ba_q[i_q]);
			end
			S_RT_E2: begin
				fa = br_i;
				alu_req.a = OPW'(free_q[br_i]);
				alu_req.b = OPW'(ba_q[i_q]);
				ram_we = alu_rsp.ge;
				ram_waddr = {i_q, br_i};
				ram_wdata = tmp_q;
			end
			S_INIT: begin
				fa = j_q;
			end
			S_SCAN: begin
				wa = br_i;
				alu_req.a = OPW'(work_rd);
				alu_req.b = OPW'(ba_q[i_q]);
			end
			S_DA_RD: begin
				ram_raddr = {i_q, j_q};
			end
			S_DA_ADD: begin
				alu_req.a = OPW'(work_rd);
				alu_req.b = OPW'(ram_rdata);
				alu_req.work_mode = 1'b1;
			end
			default: begin
				fa = r_q;
			end
		endcase
	end

	assign free_rd = free_q[fa];
	assign work_rd = work_q[wa];

	// detection scratch tables, written before they are read
	always_ff @(posedge clk) begin
		if (state_q == S_INIT) begin
			work_q[j_q] <= WW'(free_rd);
			fin_q <= ~active_q;
		end
		if (state_q == S_DA_ADD) begin
			work_q[j_q] <= alu_rsp.sum[WW-1:0];
		end
		if (state_q == S_SCAN && !fin_q[i_q] && scan_go) begin
			fin_q[i_q] <= 1'b1;
		end
	end

	// sequencer, tables and result path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			op_q <= '0;
			p_q <= '0;
			r_q <= '0;
			v_q <= '0;
			pok_q <= 1'b0;
			rok_q <= 1'b0;
			for (int k = 0; k < RESOURCES; k++) begin
				free_q[k] <= '0;
			end
			for (int k = 0; k < PROCS; k++) begin
				bres_q[k] <= '0;
				ba_q[k] <= '0;
				q_mem[k] <= '0;
			end
			active_q <= '0;
			bv_q <= '0;
			i_q <= '0;
			j_q <= '0;
			clr_q <= '0;
			rp_q <= '0;
			kill_q <= 1'b0;
			d_q <= '0;
			dval_q <= 1'b0;
			tmp_q <= '0;
			grants_q <= '0;
			q_wr_q <= '0;
			q_rd_q <= '0;
			res_valid_q <= 1'b0;
			res_status_q <= '0;
			res_proc_q <= '0;
			res_grants_q <= '0;
			res_free_q <= '0;
			res_last_q <= 1'b0;
		end else begin
			// output register drains when taken, a flush refills it itself
			if (res_valid_q && !res_stall && state_q != S_FLUSH) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						op_q <= op;
						p_q <= PW'(proc_index);
						r_q <= RW'(resource_index);
						v_q <= AB'(amount);
						pok_q <= (32'(proc_index) < PROCS);
						rok_q <= (32'(resource_index) < RESOURCES);
						grants_q <= '0;
						q_wr_q <= '0;
						q_rd_q <= '0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					unique case (op_q)
						OP_LOAD: begin
							if (rok_q) begin
								free_q[r_q] <= v_q;
							end
							q_mem[0] <= '{status: ST_DONE, proc: 4'd0};
							q_wr_q <= CW'(1);
							state_q <= S_FLUSH;
						end
						OP_START: begin
							if (!pok_q || active_q[p_q]) begin
								q_mem[0] <= '{status: pok_q ? ST_DONE : ST_DENIED, proc: 4'd0};
								q_wr_q <= CW'(1);
								state_q <= S_FLUSH;
							end else begin
								active_q[p_q] <= 1'b1;
								bv_q[p_q] <= 1'b0;
								j_q <= '0;
								state_q <= S_ZROW;
							end
						end
						OP_EXIT: begin
							if (!pok_q || !active_q[p_q]) begin
								q_mem[0] <= '{status: ST_DENIED, proc: 4'd0};
								q_wr_q <= CW'(1);
								state_q <= S_FLUSH;
							end else begin
								rp_q <= p_q;
								kill_q <= 1'b0;
								j_q <= '0;
								state_q <= S_RET_RD;
							end
						end
						OP_ACQ, OP_REL: begin
							if (!req_ok) begin
								q_mem[0] <= '{status: ST_DENIED, proc: 4'd0};
								q_wr_q <= CW'(1);
								state_q <= S_FLUSH;
							end else begin
								state_q <= (op_q == OP_ACQ) ? S_ACQ_E1 : S_REL_E1;
							end
						end
						OP_RETRY: begin
							i_q <= '0;
							state_q <= S_RT_CHK;
						end
						OP_DETECT: begin
							j_q <= '0;
							state_q <= S_INIT;
						end
						default: begin
							q_mem[0] <= '{status: ST_DENIED, proc: 4'd0};
							q_wr_q <= CW'(1);
							state_q <= S_FLUSH;
						end
					endcase
				end
				// clear the allocation row of a new process
				S_ZROW: begin
					j_q <= j_q + 1'b1;
					if (j_last) begin
						q_mem[0] <= '{status: ST_DONE, proc: 4'd0};
						q_wr_q <= CW'(1);
						state_q <= S_FLUSH;
					end
				end
				// return a row of held units to the free table
				S_RET_RD: begin
					state_q <= S_RET_ADD;
				end
				S_RET_ADD: begin
					free_q[j_q] <= alu_rsp.sum[AB-1:0];
					if (j_last) begin
						active_q[rp_q] <= 1'b0;
						bv_q[rp_q] <= 1'b0;
						q_wr_q <= q_wr_q + 1'b1;
						if (kill_q) begin
							q_mem[q_wr_q[IW-1:0]] <= '{status: ST_KILLED, proc: 4'(rp_q)};
							j_q <= '0;
							state_q <= S_INIT;
						end else begin
							q_mem[q_wr_q[IW-1:0]] <= '{status: ST_DONE, proc: 4'd0};
							state_q <= S_FLUSH;
						end
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_RET_RD;
					end
				end
				// acquire: held overflow check, then free check
				S_ACQ_E1: begin
					if (alu_rsp.ovf) begin
						q_mem[0] <= '{status: ST_DENIED, proc: 4'd0};
						q_wr_q <= CW'(1);
						state_q <= S_FLUSH;
					end else begin
						tmp_q <= alu_rsp.sum[AB-1:0];
						state_q <= S_ACQ_E2;
					end
				end
				S_ACQ_E2: begin
					if (alu_rsp.ge) begin
						free_q[r_q] <= alu_rsp.diff[AB-1:0];
						q_mem[0] <= '{status: ST_GRANTED, proc: 4'(p_q)};
					end else begin
						bv_q[p_q] <= 1'b1;
						bres_q[p_q] <= r_q;
						ba_q[p_q] <= v_q;
						q_mem[0] <= '{status: ST_BLOCKED, proc: 4'(p_q)};
					end
					q_wr_q <= CW'(1);
					state_q <= S_FLUSH;
				end
				// release: held check, then saturating refund
				S_REL_E1: begin
					if (!alu_rsp.ge) begin
						q_mem[0] <= '{status: ST_DENIED, proc: 4'd0};
						q_wr_q <= CW'(1);
						state_q <= S_FLUSH;
					end else begin
						state_q <= S_REL_E2;
					end
				end
				S_REL_E2: begin
					free_q[r_q] <= alu_rsp.sum[AB-1:0];
					q_mem[0] <= '{status: ST_RELEASED, proc: 4'd0};
					q_wr_q <= CW'(1);
					state_q <= S_FLUSH;
				end
				// retry pass over blocked requests
				S_RT_CHK, S_RT_E1, S_RT_E2: begin
					logic adv;
					logic grant;
					adv = 1'b0;
					grant = 1'b0;
					if (state_q == S_RT_CHK) begin
						if (active_q[i_q] && bv_q[i_q]) begin
							state_q <= S_RT_E1;
						end else begin
							adv = 1'b1;
						end
					end else if (state_q == S_RT_E1) begin
						if (alu_rsp.ovf) begin
							adv = 1'b1;
						end else begin
							tmp_q <= alu_rsp.sum[AB-1:0];
							state_q <= S_RT_E2;
						end
					end else begin
						adv = 1'b1;
						if (alu_rsp.ge) begin
							grant = 1'b1;
							free_q[br_i] <= alu_rsp.diff[AB-1:0];
							bv_q[i_q] <= 1'b0;
							q_mem[q_wr_q[IW-1:0]] <= '{status: ST_GRANTED, proc: 4'(i_q)};
							q_wr_q <= q_wr_q + 1'b1;
							grants_q <= grants_q + 1'b1;
						end
					end
					if (adv) begin
						if (i_last) begin
							if (!grant && q_wr_q == '0) begin
								q_mem[0] <= '{status: ST_DONE, proc: 4'd0};
								q_wr_q <= CW'(1);
							end
							state_q <= S_FLUSH;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_RT_CHK;
						end
					end
				end
				// safety check: copy free table into work
				S_INIT: begin
					j_q <= j_q + 1'b1;
					if (j_last) begin
						i_q <= '0;
						dval_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				// find a process that can finish
				S_SCAN: begin
					if (!fin_q[i_q] && scan_go) begin
						j_q <= '0;
						state_q <= S_DA_RD;
					end else begin
						if (!fin_q[i_q] && !dval_q) begin
							dval_q <= 1'b1;
							d_q <= i_q;
						end
						if (i_last) begin
							if (dval_q || !fin_q[i_q]) begin
								rp_q <= kd;
								kill_q <= 1'b1;
								j_q <= '0;
								state_q <= S_RET_RD;
							end else begin
								if (q_wr_q == '0) begin
									q_mem[0] <= '{status: ST_SAFE, proc: 4'd0};
									q_wr_q <= CW'(1);
								end
								state_q <= S_FLUSH;
							end
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				// add the finished process's row into work
				S_DA_RD: begin
					state_q <= S_DA_ADD;
				end
				S_DA_ADD: begin
					if (j_last) begin
						i_q <= '0;
						dval_q <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_DA_RD;
					end
				end
				// send queued results with final counts
				S_FLUSH: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						res_status_q <= q_head.status;
						res_proc_q <= q_head.proc;
						res_grants_q <= 5'(grants_q);
						res_free_q <= rok_q ? free_wide[7:0] : 8'd0;
						res_last_q <= q_last;
						q_rd_q <= q_rd_q + 1'b1;
						if (q_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign status = res_status_q;
	assign result_proc = res_proc_q;
	assign grant_count = res_grants_q;
	assign free_units = res_free_q;
	assign last = res_last_q;

endmodule

// ----- rtl/rdm_alu.sv -----
// ----------------------------------------------------------------------------
// rdm_alu
// Shared saturating adder and subtract/compare unit.
// ----------------------------------------------------------------------------
module rdm_alu #(
	parameter int AMOUNT_BITS = 8,
	parameter int WORK_BITS = 12
) (
	input  rdm_pkg::alu_req_t req,
	output rdm_pkg::alu_rsp_t rsp
);
	import rdm_pkg::*;

	localparam logic [OPW:0] AMOUNT_CAP = (OPW+1)'((1 << AMOUNT_BITS) - 1);
	localparam logic [OPW:0] WORK_CAP = (OPW+1)'((1 << WORK_BITS) - 1);

	logic [OPW:0] s;
	logic [OPW:0] cap;

	// add with saturation at the selected cap, compare by subtraction
	always_comb begin
		s = {1'b0, req.a} + {1'b0, req.b};
		cap = req.work_mode ? WORK_CAP : AMOUNT_CAP;
		rsp.ovf = (s > cap);
		rsp.sum = rsp.ovf ? cap[OPW-1:0] : s[OPW-1:0];
		rsp.ge = (req.a >= req.b);
		rsp.diff = req.a - req.b;
	end

endmodule

// ----- rtl/rdm_held_ram.sv -----
// ----------------------------------------------------------------------------
// rdm_held_ram
// Allocation matrix memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rdm_held_ram #(
	parameter int AW = 8,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [1 << AW];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
